[hw/rtl/i2c_register_master_unit_defines.svh]
// Assertion helpers for the RTL of the I2C register master.
`ifndef I2C_REGISTER_MASTER_UNIT_DEFINES_SVH
`define I2C_REGISTER_MASTER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Immediate implication, checked at every clock edge outside reset.
`define I2CRM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define I2CRM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define I2CRM_ASSERT_NOW(lbl, ante, cons, msg)
`define I2CRM_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[hw/rtl/i2crm_pkg.sv]
package i2crm_pkg;

    localparam int MAX_LEN = 16;
    localparam int BUF_AW  = $clog2(MAX_LEN);
    localparam int CNT_W   = $clog2(MAX_LEN + 1);
    localparam int IDX_W   = $clog2(MAX_LEN + 3);

    localparam logic [7:0] ACK_TIMEOUT_RST   = 8'd250;
    localparam logic [7:0] PHASE_DIVIDER_RST = 8'd10;

    localparam logic [1:0] MODE_TICK = 2'd0;
    localparam logic [1:0] MODE_PUSH = 2'd1;
    localparam logic [1:0] MODE_CMD  = 2'd2;
    localparam logic [1:0] MODE_NONE = 2'd3;

    localparam logic [1:0] OP_PROBE = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    localparam logic CFG_ACK_TIMEOUT   = 1'b0;
    localparam logic CFG_PHASE_DIVIDER = 1'b1;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_START1   = 4'd1,
        PH_START2   = 4'd2,
        PH_TX_LOW   = 4'd3,
        PH_TX_HIGH  = 4'd4,
        PH_ACK_LOW  = 4'd5,
        PH_ACK_WAIT = 4'd6,
        PH_RS_LOW   = 4'd7,
        PH_RX_LOW   = 4'd8,
        PH_RX_HIGH  = 4'd9,
        PH_MA_LOW   = 4'd10,
        PH_MA_HIGH  = 4'd11,
        PH_STOP1    = 4'd12,
        PH_STOP2    = 4'd13,
        PH_STOP3    = 4'd14
    } t_phase;

    // Byte to shift out for a given position in the transaction.
    function automatic logic [7:0] f_tx_byte(
        input logic [1:0]       op,
        input logic [6:0]       dev,
        input logic [7:0]       reg_a,
        input logic [IDX_W-1:0] idx,
        input logic [7:0]       entry,
        input logic             entry_ok
    );
        logic [7:0] res;
        if (idx == IDX_W'(0)) begin
            res = {dev, 1'b0};
        end else if (idx == IDX_W'(1)) begin
            res = reg_a;
        end else if (op == OP_READ) begin
            res = {dev, 1'b1};
        end else begin
            res = entry_ok ? entry : 8'd0;
        end
        return res;
    endfunction

    function automatic logic f_rx_last(
        input logic [IDX_W-1:0] idx,
        input logic [CNT_W-1:0] cnt
    );
        return ({1'b0, idx} + (IDX_W + 1)'(1)) >= (IDX_W + 1)'(cnt);
    endfunction

endpackage

[hw/rtl/i2c_register_master_unit.sv]
// The result of an accepted item is registered and appears on the next clock edge.
// One item per cycle while i_out_ready holds; the single output register refills as taken.
// Tick items, not clocks, pace the bus: max(phase_divider,1) ticks per phase but ack wait.
// Reset (synchronous, active low) returns the phase to idle, empties the write buffer count
// and restores ack_timeout to 250 and phase_divider to 10; buffer contents are not cleared.
`include "i2c_register_master_unit_defines.svh"

module i2c_register_master_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [1:0]                  i_mode,
    input  logic [1:0]                  i_op,
    input  logic [6:0]                  i_dev_addr,
    input  logic [7:0]                  i_reg_addr,
    input  logic [4:0]                  i_byte_count,
    input  logic [7:0]                  i_write_data,
    input  logic                        i_sda_in,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_scl_out,
    output logic                        o_sda_out,
    output logic                        o_busy_res,
    output logic                        o_done_res,
    output logic                        o_success,
    output logic                        o_read_valid,
    output logic [7:0]                  o_read_byte,
    output logic                        o_read_last,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic                        i_cfg_index,
    input  logic [7:0]                  i_cfg_data
);
    import i2crm_pkg::*;

    logic [7:0]       r_ack_timeout;
    logic [7:0]       r_phase_divider;

    t_phase           r_phase,     n_phase;
    logic [7:0]       r_div_cnt,   n_div_cnt;
    logic [8:0]       r_tmo_cnt,   n_tmo_cnt;
    logic [3:0]       r_bit_index, n_bit_index;
    logic [IDX_W-1:0] r_byte_index, n_byte_index;
    logic [7:0]       r_shift,     n_shift;
    logic [1:0]       r_op,        n_op;
    logic [6:0]       r_dev,       n_dev;
    logic [7:0]       r_reg,       n_reg;
    logic [CNT_W-1:0] r_cnt,       n_cnt;
    logic             r_fail,      n_fail;
    logic [CNT_W-1:0] r_fill,      n_fill;
    logic [7:0]       r_wbuf [MAX_LEN];

    logic             r_out_valid;
    logic             r_scl, r_sda, r_busy, r_done, r_ok, r_rv, r_rl;
    logic [7:0]       r_rb;
    logic             n_scl, n_sda, n_done, n_ok, n_rv, n_rl;
    logic [7:0]       n_rb;

    logic             in_acc;
    logic             wr_en;
    logic [IDX_W-1:0] load_idx;
    logic [IDX_W-1:0] buf_off;
    logic             buf_ok;
    logic [7:0]       tx_byte;
    logic [7:0]       div_eff;
    logic [7:0]       div_inc;
    logic [CNT_W-1:0] cmd_cnt;
    logic             n_last;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    // Only one byte is ever loaded per item, so one buffer read port suffices.
    assign load_idx = (r_phase == PH_ACK_WAIT) ? r_byte_index + IDX_W'(1) : r_byte_index;
    assign buf_off  = load_idx - IDX_W'(2);
    assign buf_ok   = (load_idx >= IDX_W'(2)) && (buf_off < IDX_W'(MAX_LEN));
    assign tx_byte  = f_tx_byte(r_op, r_dev, r_reg, load_idx,
                                r_wbuf[buf_off[BUF_AW-1:0]], buf_ok);

    assign div_eff = (r_phase_divider == 8'd0) ? 8'd1 : r_phase_divider;
    assign div_inc = r_div_cnt + 8'd1;

    always_comb begin
        if (i_byte_count > 5'(MAX_LEN)) begin
            cmd_cnt = CNT_W'(MAX_LEN);
        end else if (i_op == OP_READ && i_byte_count == 5'd0) begin
            cmd_cnt = CNT_W'(1);
        end else begin
            cmd_cnt = CNT_W'(i_byte_count);
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_div_cnt    = r_div_cnt;
        n_tmo_cnt    = r_tmo_cnt;
        n_bit_index  = r_bit_index;
        n_byte_index = r_byte_index;
        n_shift      = r_shift;
        n_op         = r_op;
        n_dev        = r_dev;
        n_reg        = r_reg;
        n_cnt        = r_cnt;
        n_fail       = r_fail;
        n_fill       = r_fill;
        wr_en        = 1'b0;
        n_done       = 1'b0;
        n_ok         = 1'b0;
        n_rv         = 1'b0;
        n_rb         = 8'd0;
        n_rl         = 1'b0;

        if (in_acc) begin
            unique case (i_mode)
                MODE_PUSH: begin
                    if (r_phase == PH_IDLE && r_fill < CNT_W'(MAX_LEN)) begin
                        wr_en  = 1'b1;
                        n_fill = r_fill + CNT_W'(1);
                    end
                end
                MODE_CMD: begin
                    if (r_phase == PH_IDLE && i_op != OP_NONE) begin
                        n_op         = i_op;
                        n_dev        = i_dev_addr;
                        n_reg        = i_reg_addr;
                        n_cnt        = cmd_cnt;
                        n_fail       = 1'b0;
                        n_fill       = '0;
                        n_byte_index = '0;
                        n_bit_index  = '0;
                        n_div_cnt    = '0;
                        n_tmo_cnt    = '0;
                        n_phase      = PH_START1;
                    end
                end
                MODE_TICK: begin
                    if (r_phase == PH_ACK_WAIT) begin
                        if (!i_sda_in) begin
                            n_div_cnt = '0;
                            priority if (r_op == OP_WRITE) begin
                                n_byte_index = r_byte_index + IDX_W'(1);
                                if ((IDX_W + 1)'(n_byte_index) >=
                                    (IDX_W + 1)'(r_cnt) + (IDX_W + 1)'(2)) begin
                                    n_phase = PH_STOP1;
                                end else begin
                                    n_shift     = tx_byte;
                                    n_bit_index = '0;
                                    n_phase     = PH_TX_LOW;
                                end
                            end else if (r_op == OP_READ) begin
                                if (r_byte_index == IDX_W'(0)) begin
                                    n_byte_index = IDX_W'(1);
                                    n_shift      = tx_byte;
                                    n_bit_index  = '0;
                                    n_phase      = PH_TX_LOW;
                                end else if (r_byte_index == IDX_W'(1)) begin
                                    n_byte_index = IDX_W'(2);
                                    n_phase      = PH_RS_LOW;
                                end else begin
                                    n_byte_index = '0;
                                    n_bit_index  = '0;
                                    n_shift      = '0;
                                    n_phase      = PH_RX_LOW;
                                end
                            end else begin
                                n_phase = PH_STOP1;
                            end
                        end else begin
                            if (r_tmo_cnt < 9'h1FF) begin
                                n_tmo_cnt = r_tmo_cnt + 9'd1;
                            end
                            if (n_tmo_cnt > {1'b0, r_ack_timeout}) begin
                                n_fail    = 1'b1;
                                n_div_cnt = '0;
                                n_phase   = PH_STOP1;
                            end
                        end
                    end else if (r_phase != PH_IDLE) begin
                        n_div_cnt = div_inc;
                        if (div_inc >= div_eff) begin
                            n_div_cnt = '0;
                            unique case (r_phase)
                                PH_START1: n_phase = PH_START2;
                                PH_START2: begin
                                    n_shift     = tx_byte;
                                    n_bit_index = '0;
                                    n_phase     = PH_TX_LOW;
                                end
                                PH_TX_LOW: n_phase = PH_TX_HIGH;
                                PH_TX_HIGH: begin
                                    n_bit_index = r_bit_index + 4'd1;
                                    n_phase = (n_bit_index >= 4'd8) ? PH_ACK_LOW : PH_TX_LOW;
                                end
                                PH_ACK_LOW: begin
                                    n_tmo_cnt = '0;
                                    n_phase   = PH_ACK_WAIT;
                                end
                                PH_RS_LOW: n_phase = PH_START1;
                                PH_RX_LOW: n_phase = PH_RX_HIGH;
                                PH_RX_HIGH: begin
                                    n_shift     = {r_shift[6:0], i_sda_in};
                                    n_bit_index = r_bit_index + 4'd1;
                                    if (n_bit_index >= 4'd8) begin
                                        n_rv    = 1'b1;
                                        n_rb    = n_shift;
                                        n_rl    = f_rx_last(r_byte_index, r_cnt);
                                        n_phase = PH_MA_LOW;
                                    end else begin
                                        n_phase = PH_RX_LOW;
                                    end
                                end
                                PH_MA_LOW: n_phase = PH_MA_HIGH;
                                PH_MA_HIGH: begin
                                    if (f_rx_last(r_byte_index, r_cnt)) begin
                                        n_phase = PH_STOP1;
                                    end else begin
                                        n_byte_index = r_byte_index + IDX_W'(1);
                                        n_bit_index  = '0;
                                        n_shift      = '0;
                                        n_phase      = PH_RX_LOW;
                                    end
                                end
                                PH_STOP1: n_phase = PH_STOP2;
                                PH_STOP2: n_phase = PH_STOP3;
                                PH_STOP3: begin
                                    n_phase = PH_IDLE;
                                    n_done  = 1'b1;
                                    n_ok    = !r_fail;
                                end
                                default: n_phase = PH_IDLE;
                            endcase
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Bus levels follow the state left behind by the item.
    assign n_last = f_rx_last(n_byte_index, n_cnt);

    always_comb begin
        unique case (n_phase)
            PH_START2: begin
                n_scl = 1'b1;
                n_sda = 1'b0;
            end
            PH_TX_LOW: begin
                n_scl = 1'b0;
                n_sda = n_shift[~n_bit_index[2:0]];
            end
            PH_TX_HIGH: begin
                n_scl = 1'b1;
                n_sda = n_shift[~n_bit_index[2:0]];
            end
            PH_ACK_LOW, PH_RS_LOW, PH_RX_LOW: begin
                n_scl = 1'b0;
                n_sda = 1'b1;
            end
            PH_MA_LOW: begin
                n_scl = 1'b0;
                n_sda = n_last;
            end
            PH_MA_HIGH: begin
                n_scl = 1'b1;
                n_sda = n_last;
            end
            PH_STOP1: begin
                n_scl = 1'b0;
                n_sda = 1'b0;
            end
            PH_STOP2: begin
                n_scl = 1'b1;
                n_sda = 1'b0;
            end
            default: begin
                n_scl = 1'b1;
                n_sda = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack_timeout   <= ACK_TIMEOUT_RST;
            r_phase_divider <= PHASE_DIVIDER_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ACK_TIMEOUT:   r_ack_timeout   <= i_cfg_data;
                CFG_PHASE_DIVIDER: r_phase_divider <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_div_cnt    <= '0;
            r_tmo_cnt    <= '0;
            r_bit_index  <= '0;
            r_byte_index <= '0;
            r_shift      <= '0;
            r_op         <= '0;
            r_dev        <= '0;
            r_reg        <= '0;
            r_cnt        <= '0;
            r_fail       <= 1'b0;
            r_fill       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_div_cnt    <= n_div_cnt;
            r_tmo_cnt    <= n_tmo_cnt;
            r_bit_index  <= n_bit_index;
            r_byte_index <= n_byte_index;
            r_shift      <= n_shift;
            r_op         <= n_op;
            r_dev        <= n_dev;
            r_reg        <= n_reg;
            r_cnt        <= n_cnt;
            r_fail       <= n_fail;
            r_fill       <= n_fill;
            if (in_acc) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_wbuf[r_fill[BUF_AW-1:0]] <= i_write_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_scl  <= n_scl;
            r_sda  <= n_sda;
            r_busy <= (n_phase != PH_IDLE);
            r_done <= n_done;
            r_ok   <= n_ok;
            r_rv   <= n_rv;
            r_rb   <= n_rb;
            r_rl   <= n_rl;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_scl_out    = r_scl;
    assign o_sda_out    = r_sda;
    assign o_busy_res   = r_busy;
    assign o_done_res   = r_done;
    assign o_success    = r_ok;
    assign o_read_valid = r_rv;
    assign o_read_byte  = r_rb;
    assign o_read_last  = r_rl;

    `I2CRM_ASSERT_NOW(a_done_not_busy, r_out_valid && r_done, !r_busy, "done reported while busy")
    `I2CRM_ASSERT_NOW(a_ok_needs_done, r_out_valid && r_ok, r_done, "success without done")
    `I2CRM_ASSERT_NOW(a_rx_fields_clear, r_out_valid && !r_rv,
                      (r_rb == 8'd0) && !r_rl, "read fields set without a received byte")
    `I2CRM_ASSERT_NOW(a_fill_bound, 1'b1, r_fill <= CNT_W'(MAX_LEN), "write buffer overfilled")
    `I2CRM_ASSERT_NOW(a_tx_bit_range, (r_phase == PH_TX_LOW) || (r_phase == PH_TX_HIGH),
                      r_bit_index < 4'd8, "bit index out of range while sending")
    `I2CRM_ASSERT_NEXT(a_done_goes_idle, in_acc && n_done, r_phase == PH_IDLE,
                       "bus not idle after completion")

endmodule
